### hw/rtl/iplr_pkg.sv
package iplr_pkg;

   // Limits that the register values are saturated to.
   localparam int MAX_CHANNELS = 1024;
   localparam int MAX_SIDE     = 4096;
   localparam int MAX_PATCH    = 64;

   // Field and register widths.
   localparam int DIR_W      = 1;
   localparam int CHAN_W     = 11;
   localparam int SIDE_W     = 13;
   localparam int PATCH_W    = 7;
   localparam int IDX_W      = 34;
   localparam int VAL_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Traversal counter widths.
   localparam int CH_CNT_W  = 10;
   localparam int POS_CNT_W = 12;
   localparam int IN_CNT_W  = 6;

   // Widths of the derived strides.
   localparam int PP_W  = 13;
   localparam int CPP_W = 23;
   localparam int HW_W  = 25;
   localparam int PW_W  = 19;

   // The side divider produces one quotient bit per cycle.
   localparam int DIV_STEPS = SIDE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECTION  = 3'd0,
      CSR_CHANNELS   = 3'd1,
      CSR_HEIGHT     = 3'd2,
      CSR_WIDTH      = 3'd3,
      CSR_PATCH_SIZE = 3'd4
   } iplr_csr_index_type;

   // Saturated configuration and the strides derived from it.
   typedef struct packed {
      logic                 ready;
      logic                 direction;
      logic                 blank;
      logic                 no_patch;
      logic [CHAN_W-1:0]    channels;
      logic [SIDE_W-1:0]    height;
      logic [SIDE_W-1:0]    width;
      logic [PATCH_W-1:0]   patch;
      logic [SIDE_W-1:0]    nph;
      logic [SIDE_W-1:0]    npw;
      logic [PP_W-1:0]      pp;
      logic [CPP_W-1:0]     cpp;
      logic [IDX_W-1:0]     row_stride;
      logic [HW_W-1:0]      hw;
      logic [PW_W-1:0]      pw;
   } iplr_cfg_type;

   // One result item.
   typedef struct packed {
      logic [IDX_W-1:0] dest_index;
      logic [VAL_W-1:0] out_value;
      logic             last_element;
   } iplr_rsp_type;

endpackage

### hw/rtl/iplr_setup.sv
module iplr_setup import iplr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output iplr_cfg_type          cfg
);

   typedef enum logic [5:0] {
      ST_LOAD = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_MUL1 = 6'b000100,
      ST_MUL2 = 6'b001000,
      ST_MUL3 = 6'b010000,
      ST_DONE = 6'b100000
   } setup_state_type;

   localparam int PW_PROD_W  = PATCH_W + SIDE_W;
   localparam int HW_PROD_W  = SIDE_W + SIDE_W;
   localparam int PP_PROD_W  = PATCH_W + PATCH_W;
   localparam int CPP_PROD_W = CHAN_W + PP_W;
   localparam int RS_PROD_W  = SIDE_W + CPP_W;

   setup_state_type state_ff, state_in;

   logic [DIR_W-1:0]   direction_ff;
   logic [CHAN_W-1:0]  channels_ff;
   logic [SIDE_W-1:0]  height_ff;
   logic [SIDE_W-1:0]  width_ff;
   logic [PATCH_W-1:0] patch_ff;

   logic [CHAN_W-1:0]  sat_channels;
   logic [SIDE_W-1:0]  sat_height;
   logic [SIDE_W-1:0]  sat_width;
   logic [PATCH_W-1:0] sat_patch;

   logic [STEP_W-1:0]  step_ff;
   logic [SIDE_W-1:0]  hq_ff;
   logic [SIDE_W-1:0]  wq_ff;
   logic [PATCH_W-1:0] hrem_ff;
   logic [PATCH_W-1:0] wrem_ff;
   logic [PATCH_W+SIDE_W-1:0] hdiv_next;
   logic [PATCH_W+SIDE_W-1:0] wdiv_next;

   logic [PW_PROD_W-1:0]  pw_prod;
   logic [HW_PROD_W-1:0]  hw_prod;
   logic [PP_PROD_W-1:0]  pp_prod;
   logic [CPP_PROD_W-1:0] cpp_prod;
   logic [RS_PROD_W-1:0]  rs_prod;

   logic [PP_W-1:0]  pp_ff;
   logic [HW_W-1:0]  hw_ff;
   logic [PW_W-1:0]  pw_ff;
   logic [CPP_W-1:0] cpp_ff;
   logic [IDX_W-1:0] rs_ff;

   // One restoring division step: returns the new remainder and quotient shift.
   function automatic logic [PATCH_W+SIDE_W-1:0] div_step(
      input logic [PATCH_W-1:0] rem,
      input logic [SIDE_W-1:0]  quo,
      input logic [PATCH_W-1:0] divisor
   );
      logic [PATCH_W:0] trial;
      logic [PATCH_W:0] diff;
      logic             q_bit;
      trial = {rem, quo[SIDE_W-1]};
      diff  = trial - {1'b0, divisor};
      q_bit = (trial >= {1'b0, divisor});
      if (q_bit) begin
         return {diff[PATCH_W-1:0], quo[SIDE_W-2:0], 1'b1};
      end else begin
         return {trial[PATCH_W-1:0], quo[SIDE_W-2:0], 1'b0};
      end
   endfunction

   // Register file: written at once, defaults restored by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= '0;
         channels_ff  <= CHAN_W'(3);
         height_ff    <= SIDE_W'(224);
         width_ff     <= SIDE_W'(224);
         patch_ff     <= PATCH_W'(16);
      end else if (csr_we) begin
         unique case (iplr_csr_index_type'(csr_index))
            CSR_DIRECTION:  direction_ff <= csr_wdata[DIR_W-1:0];
            CSR_CHANNELS:   channels_ff  <= csr_wdata[CHAN_W-1:0];
            CSR_HEIGHT:     height_ff    <= csr_wdata[SIDE_W-1:0];
            CSR_WIDTH:      width_ff     <= csr_wdata[SIDE_W-1:0];
            CSR_PATCH_SIZE: patch_ff     <= csr_wdata[PATCH_W-1:0];
            default: ;
         endcase
      end
   end

   // Oversized values are clamped to the supported limits.
   assign sat_channels = (channels_ff > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS)
                                                               : channels_ff;
   assign sat_height   = (height_ff > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_ff;
   assign sat_width    = (width_ff > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_ff;
   assign sat_patch    = (patch_ff > PATCH_W'(MAX_PATCH)) ? PATCH_W'(MAX_PATCH) : patch_ff;

   // Sequencer: any write restarts the derivation of the strides.
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  state_in = (step_ff == STEP_W'(DIV_STEPS - 1)) ? ST_MUL1 : ST_DIV;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_DONE;
         ST_DONE: state_in = ST_DONE;
         default: state_in = ST_LOAD;
      endcase
   end

   assign hdiv_next = div_step(hrem_ff, hq_ff, sat_patch);
   assign wdiv_next = div_step(wrem_ff, wq_ff, sat_patch);

   assign pw_prod  = PW_PROD_W'(sat_patch) * PW_PROD_W'(sat_width);
   assign hw_prod  = HW_PROD_W'(sat_height) * HW_PROD_W'(sat_width);
   assign pp_prod  = PP_PROD_W'(sat_patch) * PP_PROD_W'(sat_patch);
   assign cpp_prod = CPP_PROD_W'(sat_channels) * CPP_PROD_W'(pp_ff);
   assign rs_prod  = RS_PROD_W'(wq_ff) * RS_PROD_W'(cpp_ff);

   // Datapath of the sequencer: two dividers side by side, then the products.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            hq_ff   <= sat_height;
            wq_ff   <= sat_width;
            hrem_ff <= '0;
            wrem_ff <= '0;
            step_ff <= '0;
         end
         ST_DIV: begin
            {hrem_ff, hq_ff} <= hdiv_next;
            {wrem_ff, wq_ff} <= wdiv_next;
            step_ff          <= step_ff + STEP_W'(1);
         end
         ST_MUL1: begin
            pp_ff <= pp_prod[PP_W-1:0];
            hw_ff <= hw_prod[HW_W-1:0];
            pw_ff <= pw_prod[PW_W-1:0];
         end
         ST_MUL2: cpp_ff <= cpp_prod[CPP_W-1:0];
         ST_MUL3: rs_ff  <= rs_prod[IDX_W-1:0];
         default: ;
      endcase
   end

   always_comb begin
      cfg.ready      = (state_ff == ST_DONE);
      cfg.direction  = direction_ff[0];
      cfg.blank      = (sat_channels == '0) || (sat_height == '0) ||
                       (sat_width == '0) || (sat_patch == '0);
      cfg.no_patch   = (hq_ff == '0) || (wq_ff == '0);
      cfg.channels   = sat_channels;
      cfg.height     = sat_height;
      cfg.width      = sat_width;
      cfg.patch      = sat_patch;
      cfg.nph        = hq_ff;
      cfg.npw        = wq_ff;
      cfg.pp         = pp_ff;
      cfg.cpp        = cpp_ff;
      cfg.row_stride = rs_ff;
      cfg.hw         = hw_ff;
      cfg.pw         = pw_ff;
   end

endmodule

### hw/rtl/iplr_rsp_buf.sv
module iplr_rsp_buf import iplr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  iplr_rsp_type in_data,
   output logic         in_ready,
   output logic         out_valid,
   output iplr_rsp_type out_data,
   input  logic         out_ready
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   iplr_rsp_type out_data_ff, out_data_in;
   iplr_rsp_type skid_data_ff, skid_data_in;
   logic         out_free;

   // The skid stage catches an item that arrives while the output stalls.
   assign out_free = !out_valid_ff || out_ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### hw/rtl/image_patch_layout_remap.sv
// Channel  Ports                                   Role
// req      req_valid, req_ready, req_element_value  source-order element items in
// rsp      rsp_valid, rsp_ready, rsp_dest_index,    remapped element items out
//          rsp_out_value, rsp_last_element
// csr      csr_we, csr_index, csr_wdata             register writes, no wait
//
// One item is accepted per cycle while req_ready is high; each result is registered in the output stage.
// After reset and after every register write, the stride sequencer runs
// (one load, 13 divider steps for the patch counts, three multiply stages) with req_ready low.
// Reset and any register write return the traversal to the tensor start.
// A two-entry output stage keeps req_ready high while one result waits on rsp_ready.
module image_patch_layout_remap import iplr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VAL_W-1:0]      req_element_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W-1:0]      rsp_dest_index,
   output logic [VAL_W-1:0]      rsp_out_value,
   output logic                  rsp_last_element,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   iplr_cfg_type cfg;
   iplr_rsp_type push_data, rsp_data;
   logic         push, buf_ready, acc;

   // Traversal position shared by both directions.
   logic [CH_CNT_W-1:0]  ch_ff, ch_in;
   logic [POS_CNT_W-1:0] pr_ff, pr_in;
   logic [POS_CNT_W-1:0] pc_ff, pc_in;
   logic [IN_CNT_W-1:0]  rip_ff, rip_in;
   logic [IN_CNT_W-1:0]  cip_ff, cip_in;
   // Image coordinates, forward direction only.
   logic [POS_CNT_W-1:0] x_ff, x_in;
   logic [POS_CNT_W-1:0] y_ff, y_in;

   // Forward running bases.
   logic [IDX_W-1:0] ch_base_ff, ch_base_in;
   logic [IDX_W-1:0] prc_base_ff, prc_base_in;
   logic [IDX_W-1:0] row_base_ff, row_base_in;
   logic [IDX_W-1:0] pc_base_ff, pc_base_in;
   logic [IDX_W-1:0] col_off_ff, col_off_in;
   // Inverse running bases.
   logic [IDX_W-1:0] prow_base_ff, prow_base_in;
   logic [IDX_W-1:0] pat_base_ff, pat_base_in;
   logic [IDX_W-1:0] pch_base_ff, pch_base_in;
   logic [IDX_W-1:0] line_base_ff, line_base_in;

   logic ch_end, ch_is_last, pr_end, pr_is_last, pc_end, pc_is_last;
   logic rip_end, rip_is_last, cip_end, cip_is_last;
   logic row_ok, col_ok, x_end, y_end;
   logic fwd_emit, fwd_last, inv_last;
   logic [IDX_W-1:0] fwd_dest, inv_dest;
   logic [IDX_W-1:0] ch_base_step, prc_base_step, row_base_step, pc_base_step, col_off_step;
   logic [IDX_W-1:0] line_step, pch_step, pat_step, prow_step;

   iplr_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_ready = cfg.ready && buf_ready;
   assign acc       = req_valid && req_ready;

   // Position compares.
   assign ch_end      = ({1'b0, ch_ff} + CHAN_W'(1)) >= cfg.channels;
   assign ch_is_last  = ({1'b0, ch_ff} + CHAN_W'(1)) == cfg.channels;
   assign pr_end      = ({1'b0, pr_ff} + SIDE_W'(1)) >= cfg.nph;
   assign pr_is_last  = ({1'b0, pr_ff} + SIDE_W'(1)) == cfg.nph;
   assign pc_end      = ({1'b0, pc_ff} + SIDE_W'(1)) >= cfg.npw;
   assign pc_is_last  = ({1'b0, pc_ff} + SIDE_W'(1)) == cfg.npw;
   assign rip_end     = ({1'b0, rip_ff} + PATCH_W'(1)) >= cfg.patch;
   assign rip_is_last = ({1'b0, rip_ff} + PATCH_W'(1)) == cfg.patch;
   assign cip_end     = ({1'b0, cip_ff} + PATCH_W'(1)) >= cfg.patch;
   assign cip_is_last = ({1'b0, cip_ff} + PATCH_W'(1)) == cfg.patch;
   assign row_ok      = {1'b0, pr_ff} < cfg.nph;
   assign col_ok      = {1'b0, pc_ff} < cfg.npw;
   assign x_end       = ({1'b0, x_ff} + SIDE_W'(1)) >= cfg.width;
   assign y_end       = ({1'b0, y_ff} + SIDE_W'(1)) >= cfg.height;

   // Forward: only elements inside a whole patch are emitted.
   assign fwd_emit = row_ok && col_ok;
   assign fwd_last = fwd_emit && ch_is_last && pr_is_last && rip_is_last &&
                     pc_is_last && cip_is_last;
   assign fwd_dest = row_base_ff + col_off_ff;
   assign inv_last = cip_is_last && rip_is_last && ch_is_last && pc_is_last && pr_is_last;
   assign inv_dest = line_base_ff + IDX_W'(cip_ff);

   // Stride steps of the running bases.
   assign ch_base_step  = ch_base_ff + IDX_W'(cfg.pp);
   assign prc_base_step = prc_base_ff + cfg.row_stride;
   assign row_base_step = row_base_ff + IDX_W'(cfg.patch);
   assign pc_base_step  = pc_base_ff + IDX_W'(cfg.cpp);
   assign col_off_step  = col_off_ff + IDX_W'(1);
   assign line_step     = line_base_ff + IDX_W'(cfg.width);
   assign pch_step      = pch_base_ff + IDX_W'(cfg.hw);
   assign pat_step      = pat_base_ff + IDX_W'(cfg.patch);
   assign prow_step     = prow_base_ff + IDX_W'(cfg.pw);

   // Next position for an accepted item.
   always_comb begin
      ch_in        = ch_ff;
      pr_in        = pr_ff;
      pc_in        = pc_ff;
      rip_in       = rip_ff;
      cip_in       = cip_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ch_base_in   = ch_base_ff;
      prc_base_in  = prc_base_ff;
      row_base_in  = row_base_ff;
      pc_base_in   = pc_base_ff;
      col_off_in   = col_off_ff;
      prow_base_in = prow_base_ff;
      pat_base_in  = pat_base_ff;
      pch_base_in  = pch_base_ff;
      line_base_in = line_base_ff;
      push         = 1'b0;

      if (acc && !cfg.blank) begin
         if (!cfg.direction) begin
            push = fwd_emit;
            if (x_end) begin
               x_in       = '0;
               pc_in      = '0;
               cip_in     = '0;
               pc_base_in = '0;
               col_off_in = '0;
               if (y_end) begin
                  y_in   = '0;
                  pr_in  = '0;
                  rip_in = '0;
                  if (ch_end) begin
                     ch_in       = '0;
                     ch_base_in  = '0;
                     prc_base_in = '0;
                     row_base_in = '0;
                  end else begin
                     ch_in       = ch_ff + CH_CNT_W'(1);
                     ch_base_in  = ch_base_step;
                     prc_base_in = ch_base_step;
                     row_base_in = ch_base_step;
                  end
               end else begin
                  y_in = y_ff + POS_CNT_W'(1);
                  if (row_ok && rip_end) begin
                     rip_in      = '0;
                     pr_in       = pr_ff + POS_CNT_W'(1);
                     prc_base_in = prc_base_step;
                     row_base_in = prc_base_step;
                  end else begin
                     rip_in      = rip_ff + IN_CNT_W'(1);
                     row_base_in = row_base_step;
                  end
               end
            end else if (col_ok) begin
               x_in = x_ff + POS_CNT_W'(1);
               if (cip_end) begin
                  cip_in     = '0;
                  pc_in      = pc_ff + POS_CNT_W'(1);
                  pc_base_in = pc_base_step;
                  col_off_in = pc_base_step;
               end else begin
                  cip_in     = cip_ff + IN_CNT_W'(1);
                  col_off_in = col_off_step;
               end
            end else begin
               x_in = x_ff + POS_CNT_W'(1);
            end
         end else if (!cfg.no_patch) begin
            // Inverse: column, row, channel, patch column, patch row.
            push = 1'b1;
            if (!cip_end) begin
               cip_in = cip_ff + IN_CNT_W'(1);
            end else begin
               cip_in = '0;
               if (!rip_end) begin
                  rip_in       = rip_ff + IN_CNT_W'(1);
                  line_base_in = line_step;
               end else begin
                  rip_in = '0;
                  if (!ch_end) begin
                     ch_in        = ch_ff + CH_CNT_W'(1);
                     pch_base_in  = pch_step;
                     line_base_in = pch_step;
                  end else begin
                     ch_in = '0;
                     if (!pc_end) begin
                        pc_in        = pc_ff + POS_CNT_W'(1);
                        pat_base_in  = pat_step;
                        pch_base_in  = pat_step;
                        line_base_in = pat_step;
                     end else begin
                        pc_in = '0;
                        if (!pr_end) begin
                           pr_in        = pr_ff + POS_CNT_W'(1);
                           prow_base_in = prow_step;
                           pat_base_in  = prow_step;
                           pch_base_in  = prow_step;
                           line_base_in = prow_step;
                        end else begin
                           pr_in        = '0;
                           prow_base_in = '0;
                           pat_base_in  = '0;
                           pch_base_in  = '0;
                           line_base_in = '0;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   // Position registers; a register write restarts the tensor.
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         ch_ff        <= '0;
         pr_ff        <= '0;
         pc_ff        <= '0;
         rip_ff       <= '0;
         cip_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         ch_base_ff   <= '0;
         prc_base_ff  <= '0;
         row_base_ff  <= '0;
         pc_base_ff   <= '0;
         col_off_ff   <= '0;
         prow_base_ff <= '0;
         pat_base_ff  <= '0;
         pch_base_ff  <= '0;
         line_base_ff <= '0;
      end else begin
         ch_ff        <= ch_in;
         pr_ff        <= pr_in;
         pc_ff        <= pc_in;
         rip_ff       <= rip_in;
         cip_ff       <= cip_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         ch_base_ff   <= ch_base_in;
         prc_base_ff  <= prc_base_in;
         row_base_ff  <= row_base_in;
         pc_base_ff   <= pc_base_in;
         col_off_ff   <= col_off_in;
         prow_base_ff <= prow_base_in;
         pat_base_ff  <= pat_base_in;
         pch_base_ff  <= pch_base_in;
         line_base_ff <= line_base_in;
      end
   end

   // Result item assembled from the current position.
   always_comb begin
      push_data.dest_index   = cfg.direction ? inv_dest : fwd_dest;
      push_data.out_value    = req_element_value;
      push_data.last_element = cfg.direction ? inv_last : fwd_last;
   end

   iplr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_data   (push_data),
      .in_ready  (buf_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (rsp_ready)
   );

   assign rsp_dest_index   = rsp_data.dest_index;
   assign rsp_out_value    = rsp_data.out_value;
   assign rsp_last_element = rsp_data.last_element;

`ifndef SYNTHESIS
   // A register write returns the traversal to the tensor start.
   a_clear_on_write: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (ch_ff == '0 && pr_ff == '0 && pc_ff == '0 && x_ff == '0 && y_ff == '0))
      else $error("position not cleared after register write");

   // The forward column counter never leaves the image.
   a_x_in_image: assert property (@(posedge clock) disable iff (reset)
      (!cfg.blank && !cfg.direction) |-> ({1'b0, x_ff} < cfg.width))
      else $error("forward column beyond image width");

   // An emitted forward element lies inside its patch.
   a_emit_in_patch: assert property (@(posedge clock) disable iff (reset)
      (acc && !cfg.blank && !cfg.direction && fwd_emit) |->
         ({1'b0, cip_ff} < cfg.patch && {1'b0, rip_ff} < cfg.patch))
      else $error("forward element outside its patch");

   // The final inverse element wraps the traversal back to the start.
   a_inv_wrap: assert property (@(posedge clock) disable iff (reset)
      (acc && cfg.direction && !cfg.blank && !cfg.no_patch && inv_last) |=>
         (cip_ff == '0 && rip_ff == '0 && ch_ff == '0 && pc_ff == '0 &&
          pr_ff == '0 && line_base_ff == '0))
      else $error("inverse traversal did not wrap after the final element");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import iplr_pkg::*;

   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 6;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 100;
   localparam int RANDOM_ITEMS   = 400;
   localparam int MAX_REPORTS    = 10;

   // Register indexes that decode to nothing but still rewind the traversal.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam bit DIR_TO_PATCHES = 1'b0;
   localparam bit DIR_TO_IMAGE   = 1'b1;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [VAL_W-1:0]      req_element_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [IDX_W-1:0]      rsp_dest_index;
   logic [VAL_W-1:0]      rsp_out_value;
   logic                  rsp_last_element;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   image_patch_layout_remap u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_out_value     (rsp_out_value),
      .rsp_last_element  (rsp_last_element),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Element items waiting to be offered, and remapped items still owed by the block.
   logic [VAL_W-1:0] element_q[$];
   iplr_rsp_type     remap_q[$];

   int snd_idle_pct  = 7;
   int rcv_idle_pct  = 49;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int mismatch_count = 0;
   int stall_cycles  = 0;

   // Register values as written, before saturation.
   bit                lay_dir    = DIR_TO_PATCHES;
   logic [CHAN_W-1:0] lay_chan   = 11'd3;
   logic [SIDE_W-1:0] lay_height = 13'd224;
   logic [SIDE_W-1:0] lay_width  = 13'd224;
   logic [PATCH_W-1:0] lay_patch = 7'd16;

   // Current traversal position.
   logic [CH_CNT_W-1:0]  at_chan = '0;
   logic [POS_CNT_W-1:0] at_prow = '0;
   logic [POS_CNT_W-1:0] at_pcol = '0;
   logic [IN_CNT_W-1:0]  at_rip  = '0;
   logic [IN_CNT_W-1:0]  at_cip  = '0;
   logic [POS_CNT_W-1:0] at_lcol = '0;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Works out where one element lands and moves the position on; returns 1 if it is kept.
   function automatic bit remap_index(input logic [VAL_W-1:0] value,
                                      output iplr_rsp_type res);
      longint unsigned c, h, w, p, nph, npw, y, x, dest;
      bit row_ok, col_ok, emit, last;
      res = '0;
      c = (lay_chan > MAX_CHANNELS) ? MAX_CHANNELS : lay_chan;
      h = (lay_height > MAX_SIDE) ? MAX_SIDE : lay_height;
      w = (lay_width > MAX_SIDE) ? MAX_SIDE : lay_width;
      p = (lay_patch > MAX_PATCH) ? MAX_PATCH : lay_patch;
      if (c == 0 || h == 0 || w == 0 || p == 0)
         return 0;
      nph = h / p;
      npw = w / p;
      if (lay_dir == DIR_TO_PATCHES) begin
         row_ok = at_prow < nph;
         col_ok = at_pcol < npw;
         y = at_prow * p + at_rip;
         x = at_pcol * p + (col_ok ? at_cip : at_lcol);
         emit = row_ok && col_ok;
         last = emit && at_chan + 1 == c && y + 1 == nph * p && x + 1 == npw * p;
         dest = ((at_prow * npw + at_pcol) * c + at_chan) * p * p + at_rip * p + at_cip;
         // Raster walk: column innermost, leftover columns and rows counted apart.
         if (x + 1 >= w) begin
            at_pcol = '0;
            at_cip  = '0;
            at_lcol = '0;
            if (y + 1 >= h) begin
               at_prow = '0;
               at_rip  = '0;
               at_chan = (at_chan + 1 >= c) ? '0 : at_chan + 1'b1;
            end else if (row_ok && at_rip + 1 >= p) begin
               at_rip  = '0;
               at_prow = at_prow + 1'b1;
            end else begin
               at_rip = at_rip + 1'b1;
            end
         end else if (col_ok) begin
            if (at_cip + 1 >= p) begin
               at_cip  = '0;
               at_pcol = at_pcol + 1'b1;
            end else begin
               at_cip = at_cip + 1'b1;
            end
         end else begin
            at_lcol = at_lcol + 1'b1;
         end
      end else begin
         if (nph == 0 || npw == 0)
            return 0;
         emit = 1'b1;
         dest = at_chan * h * w + (at_prow * p + at_rip) * w + at_pcol * p + at_cip;
         last = at_cip + 1 == p && at_rip + 1 == p && at_chan + 1 == c &&
                at_pcol + 1 == npw && at_prow + 1 == nph;
         // Patch order: column in patch innermost, then row, channel, patch column, patch row.
         if (at_cip + 1 >= p) begin
            at_cip = '0;
            if (at_rip + 1 >= p) begin
               at_rip = '0;
               if (at_chan + 1 >= c) begin
                  at_chan = '0;
                  if (at_pcol + 1 >= npw) begin
                     at_pcol = '0;
                     at_prow = (at_prow + 1 >= nph) ? '0 : at_prow + 1'b1;
                  end else begin
                     at_pcol = at_pcol + 1'b1;
                  end
               end else begin
                  at_chan = at_chan + 1'b1;
               end
            end else begin
               at_rip = at_rip + 1'b1;
            end
         end else begin
            at_cip = at_cip + 1'b1;
         end
      end
      res.dest_index   = IDX_W'(dest);
      res.out_value    = value;
      res.last_element = last;
      return emit;
   endfunction

   function automatic logic [VAL_W-1:0] pick_element();
      if ($urandom_range(7) == 0)
         return {VAL_W{1'($urandom)}};
      return VAL_W'($urandom);
   endfunction

   task automatic report_remap(input string what, input iplr_rsp_type want,
                               input iplr_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected index %0d value %h last %b, got index %0d value %h last %b",
                  $time, what, want.dest_index, want.out_value, want.last_element,
                  got.dest_index, got.out_value, got.last_element);
   endtask

   // One register write; any write rewinds the traversal to the tensor start.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_DIRECTION:  lay_dir    = data[0];
         CSR_CHANNELS:   lay_chan   = data[CHAN_W-1:0];
         CSR_HEIGHT:     lay_height = data[SIDE_W-1:0];
         CSR_WIDTH:      lay_width  = data[SIDE_W-1:0];
         CSR_PATCH_SIZE: lay_patch  = data[PATCH_W-1:0];
         default: ;
      endcase
      at_chan = '0;
      at_prow = '0;
      at_pcol = '0;
      at_rip  = '0;
      at_cip  = '0;
      at_lcol = '0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every item is in and every remapped item is out, then lets the pipe drain.
   task automatic settle();
      @(negedge clock);
      while (element_q.size() != 0 || req_valid || remap_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sets up one layout and queues n elements. With junk set the unused upper data
   // bits of the narrow registers carry noise.
   task automatic run_layout(input bit dir, input int c, input int h, input int w,
                             input int p, input int n, input bit junk);
      settle();
      write_reg(CSR_DIRECTION, junk ? {12'($urandom), dir} : CSR_DATA_W'(dir));
      write_reg(CSR_CHANNELS, junk ? {2'($urandom), 11'(c)} : CSR_DATA_W'(c));
      write_reg(CSR_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_PATCH_SIZE, junk ? {6'($urandom), 7'(p)} : CSR_DATA_W'(p));
      repeat (n) element_q.push_back(pick_element());
   endtask

   // Sender: offers queued elements, holding each one steady until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (element_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            req_valid         <= 1'b1;
            req_element_value <= element_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus a long hold whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Predicts on every accepted element and checks every accepted remapped item.
   always @(posedge clock) begin : check_remaps
      iplr_rsp_type want;
      iplr_rsp_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (remap_index(req_element_value, want))
               remap_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got.dest_index   = rsp_dest_index;
            got.out_value    = rsp_out_value;
            got.last_element = rsp_last_element;
            if (remap_q.size() == 0) begin
               report_remap("item with nothing expected", '0, got);
            end else begin
               want = remap_q.pop_front();
               if (got.dest_index !== want.dest_index || got.out_value !== want.out_value ||
                   got.last_element !== want.last_element)
                  report_remap("remap mismatch", want, got);
            end
         end
      end
   end

   // Watchdog on cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int  random_items;
      int  c, h, w, p, nph, npw, tensor_items, pick;
      bit  dir, pressed;
      random_items = 0;
      pressed = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset layout, with the value extremes.
      element_q.push_back(16'h0000);
      element_q.push_back(16'hFFFF);
      element_q.push_back(16'h8000);
      element_q.push_back(16'h7FFF);
      // One-element tensor: every item is the last one.
      run_layout(DIR_TO_PATCHES, 1, 1, 1, 1, 2, 1'b0);
      // Leftover row and column past the only whole patch.
      run_layout(DIR_TO_PATCHES, 1, 3, 3, 2, 9, 1'b0);
      run_layout(DIR_TO_IMAGE, 1, 2, 3, 2, 4, 1'b0);
      // Oversized registers saturate; then the largest legal channel count and sides.
      run_layout(DIR_TO_PATCHES, 2047, 8191, 8191, 127, 2, 1'b0);
      run_layout(DIR_TO_IMAGE, MAX_CHANNELS, MAX_SIDE, MAX_SIDE, 1, 2, 1'b0);
      // A zero register drops everything.
      run_layout(DIR_TO_PATCHES, 0, 4, 4, 2, 1, 1'b0);
      run_layout(DIR_TO_IMAGE, 2, 0, 4, 2, 1, 1'b0);
      run_layout(DIR_TO_PATCHES, 2, 4, 0, 2, 1, 1'b0);
      run_layout(DIR_TO_IMAGE, 2, 4, 4, 0, 1, 1'b0);
      // Patch taller than the image: nothing is kept in either direction.
      run_layout(DIR_TO_PATCHES, 1, 2, 3, 3, 6, 1'b0);
      run_layout(DIR_TO_IMAGE, 1, 2, 3, 3, 2, 1'b0);

      // Random layouts, mostly whole tensors, over three idling phases.
      while (random_items < RANDOM_ITEMS) begin
         if (random_items < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 7;
            rcv_idle_pct = 49;
         end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 49;
            rcv_idle_pct = 7;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
            if (!pressed) begin
               // Long receiver hold while the sender keeps offering, so the block backs up.
               pressed = 1'b1;
               run_layout(DIR_TO_PATCHES, 3, 6, 6, 2, 108, 1'b1);
               hold_requests++;
               random_items += 108;
            end
         end
         dir = 1'($urandom_range(1));
         c = $urandom_range(3, 1);
         p = $urandom_range(3, 1);
         h = ($urandom_range(9) == 0) ? $urandom_range(p, 1) : $urandom_range(2 * p + 2, p);
         w = ($urandom_range(9) == 0) ? $urandom_range(p, 1) : $urandom_range(2 * p + 2, p);
         nph = h / p;
         npw = w / p;
         tensor_items = (dir == DIR_TO_PATCHES) ? c * h * w : nph * npw * c * p * p;
         if (nph == 0 || npw == 0) begin
            run_layout(dir, c, h, w, p, $urandom_range(8, 1), 1'b1);
         end else begin
            pick = $urandom_range(9);
            if (pick < 2) begin
               // Abandon a tensor part way through with a write to an unused index.
               run_layout(dir, c, h, w, p, $urandom_range(tensor_items, 1), 1'b1);
               settle();
               write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)),
                         CSR_DATA_W'($urandom));
               repeat (tensor_items) element_q.push_back(pick_element());
               random_items += 2 * tensor_items;
            end else if (pick == 2) begin
               run_layout(dir, c, h, w, p, 2 * tensor_items, 1'b1);
               random_items += 2 * tensor_items;
            end else begin
               run_layout(dir, c, h, w, p, tensor_items, 1'b1);
               random_items += tensor_items;
            end
         end
      end

      settle();
      if (mismatch_count == 0 && remap_q.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
